FILE: hdl/ppnd_pkg.sv
// shared types, constants and helpers for the palette thumbnail downscaler
// no dependencies; used by every module of the block
`default_nettype none

package ppnd_pkg;

    // field and counter widths
    localparam int DIM_W     = 13;
    localparam int OUT_W     = 12;
    localparam int IDX_W     = 8;
    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 3 * COLOR_W;
    localparam int ERR_W     = DIM_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(DIM_W);

    // largest dimension honoured, anything above is clamped
    localparam int MAX_DIM  = 4096;
    localparam int DIM_CEIL = (1 << DIM_W) - 1;
    localparam logic [DIM_W-1:0] DIM_LIMIT =
        DIM_W'((MAX_DIM > DIM_CEIL) ? DIM_CEIL : MAX_DIM);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIZE = 2'd2;

    // request function codes
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_PIXEL     = 1'b1;

    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   color_index;
        logic [COLOR_W-1:0] entry_red;
        logic [COLOR_W-1:0] entry_green;
        logic [COLOR_W-1:0] entry_blue;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0]   out_col;
        logic [OUT_W-1:0]   out_row;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last_pixel;
    } t_out_item;

    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_WIDTH,
        DIV_HEIGHT
    } t_div_sel;

    typedef enum logic [2:0] {
        S_RUN,
        S_SC_LOAD,
        S_SC_RUN,
        S_W_LOAD,
        S_W_RUN,
        S_H_LOAD,
        S_H_RUN,
        S_FIRST
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     pal_wr;
        logic     proc;
        logic     use_held;
        logic     frame_init;
        logic     div_start;
        t_div_sel div_sel;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic at_start;
        logic out_free;
        logic div_done;
    } t_ctrl_stat;

    // zero reads as one, oversize reads as the limit
    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_LIMIT) begin
            r = DIM_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ppnd_div.sv
// restoring divider, one quotient bit per cycle
// depends on ppnd_pkg for the operand width
`default_nettype none

module ppnd_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ppnd_pkg::DIM_W-1:0] i_dividend,
    input  wire logic [ppnd_pkg::DIM_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [ppnd_pkg::DIM_W-1:0]      o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [ppnd_pkg::STEP_W-1:0]       r_step;
    logic [ppnd_pkg::DIM_W-1:0]        r_rem;
    logic [ppnd_pkg::DIM_W-1:0]        r_quo;
    logic [ppnd_pkg::DIM_W-1:0]        r_dvs;
    logic [ppnd_pkg::DIM_W:0]          trial;
    logic                              step_last;

    assign trial     = {r_rem, r_quo[ppnd_pkg::DIM_W-1]} - {1'b0, r_dvs};
    assign step_last = (r_step == ppnd_pkg::STEP_W'(ppnd_pkg::DIM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + ppnd_pkg::STEP_W'(1);
                r_busy <= !step_last;
                r_done <= step_last;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!trial[ppnd_pkg::DIM_W]) begin
                r_rem <= trial[ppnd_pkg::DIM_W-1:0];
                r_quo <= {r_quo[ppnd_pkg::DIM_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[ppnd_pkg::DIM_W-2:0], r_quo[ppnd_pkg::DIM_W-1]};
                r_quo <= {r_quo[ppnd_pkg::DIM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");
`endif

endmodule

`default_nettype wire

FILE: hdl/ppnd_dp.sv
// datapath: configuration registers, palette memory, scan counters, output register
// depends on ppnd_pkg and ppnd_div
`default_nettype none

module ppnd_dp #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ppnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ppnd_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire ppnd_pkg::t_in_item             i_in_data,
    input  wire logic                           i_out_ready,
    input  wire ppnd_pkg::t_ctrl_cmd            i_cmd,
    output ppnd_pkg::t_ctrl_stat                o_stat,
    output logic                                o_out_valid,
    output ppnd_pkg::t_out_item                 o_out_data
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam logic [ppnd_pkg::IDX_W:0] DEPTH_L = (ppnd_pkg::IDX_W + 1)'(PALETTE_DEPTH);

    localparam int DW = ppnd_pkg::DIM_W;
    localparam int EW = ppnd_pkg::ERR_W;

    // configuration
    logic [DW-1:0] r_cfg_w;
    logic [DW-1:0] r_cfg_h;
    logic [DW-1:0] r_cfg_t;

    // frame geometry
    logic [DW-1:0] r_frame_w;
    logic [DW-1:0] r_frame_h;
    logic [DW-1:0] r_tgt;
    logic [DW-1:0] r_scale;
    logic [DW-1:0] r_tw;
    logic [DW-1:0] r_th;

    // scan position and stepping error terms
    logic [DW-1:0] r_src_col;
    logic [DW-1:0] r_src_row;
    logic [DW-1:0] r_dst_col;
    logic [DW-1:0] r_dst_row;
    logic [EW-1:0] r_err_col;
    logic [EW-1:0] r_err_row;

    logic [ppnd_pkg::IDX_W-1:0] r_idx;

    logic [ppnd_pkg::RGB_W-1:0] r_pal [PALETTE_DEPTH];

    logic                         r_out_valid;
    logic [ppnd_pkg::OUT_W-1:0]   r_out_col;
    logic [ppnd_pkg::OUT_W-1:0]   r_out_row;
    logic                         r_out_last;
    logic [ppnd_pkg::RGB_W-1:0]   r_rgb;

    logic [ppnd_pkg::IDX_W-1:0] proc_idx;
    logic                       wr_in_range;
    logic                       rd_in_range;
    logic                       row_hit;
    logic                       col_hit;
    logic                       row_end;
    logic                       frame_end;
    logic                       last_pix;
    logic [DW-1:0]              div_dividend;
    logic [DW-1:0]              div_divisor;
    logic                       div_done;
    logic [DW-1:0]              div_quo;
    logic [DW-1:0]              clamp_w;
    logic [DW-1:0]              clamp_h;
    logic [DW-1:0]              clamp_t;

    assign clamp_w = ppnd_pkg::f_clamp_dim(r_cfg_w);
    assign clamp_h = ppnd_pkg::f_clamp_dim(r_cfg_h);
    assign clamp_t = ppnd_pkg::f_clamp_dim(r_cfg_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DW'(1);
            r_cfg_h <= DW'(1);
            r_cfg_t <= DW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppnd_pkg::CFG_SRC_WIDTH:   r_cfg_w <= i_cfg_data;
                ppnd_pkg::CFG_SRC_HEIGHT:  r_cfg_h <= i_cfg_data;
                ppnd_pkg::CFG_TARGET_SIZE: r_cfg_t <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared divider for scale, thumbnail width and height
    always_comb begin
        div_dividend = clamp_w;
        div_divisor  = clamp_t;
        unique case (i_cmd.div_sel)
            ppnd_pkg::DIV_SCALE: begin
                div_dividend = clamp_w;
                div_divisor  = clamp_t;
            end
            ppnd_pkg::DIV_WIDTH: begin
                div_dividend = r_frame_w;
                div_divisor  = r_scale;
            end
            ppnd_pkg::DIV_HEIGHT: begin
                div_dividend = r_frame_h;
                div_divisor  = r_scale;
            end
            default: ;
        endcase
    end

    ppnd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign proc_idx    = i_cmd.use_held ? r_idx : i_in_data.color_index;
    assign wr_in_range = {1'b0, i_in_data.color_index} < DEPTH_L;
    assign rd_in_range = {1'b0, proc_idx} < DEPTH_L;

    // row and column kept when the error term sits below the thumbnail size
    assign row_hit = (r_th != '0) && (r_dst_row < r_th) && (r_err_row < {1'b0, r_th});
    assign col_hit = row_hit && (r_dst_col < r_tw) && (r_err_col < {1'b0, r_tw});
    assign row_end   = (r_src_col == r_frame_w - DW'(1));
    assign frame_end = (r_src_row == r_frame_h - DW'(1));
    assign last_pix  = ({1'b0, r_dst_row} + EW'(1) == {1'b0, r_th})
                    && ({1'b0, r_dst_col} + EW'(1) == {1'b0, r_tw});

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= i_in_data.color_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= '0;
            r_frame_h <= '0;
            r_tgt     <= '0;
            r_scale   <= DW'(1);
            r_tw      <= '0;
            r_th      <= '0;
            r_src_col <= '0;
            r_src_row <= '0;
            r_dst_col <= '0;
            r_dst_row <= '0;
            r_err_col <= '0;
            r_err_row <= '0;
        end else begin
            if (i_cmd.frame_init) begin
                r_frame_w <= clamp_w;
                r_frame_h <= clamp_h;
                r_tgt     <= clamp_t;
                r_dst_col <= '0;
                r_dst_row <= '0;
                r_err_col <= '0;
                r_err_row <= '0;
            end
            if (div_done) begin
                unique case (i_cmd.div_sel)
                    ppnd_pkg::DIV_SCALE:  r_scale <= (r_frame_w > r_tgt) ? div_quo : DW'(1);
                    ppnd_pkg::DIV_WIDTH:  r_tw    <= div_quo;
                    ppnd_pkg::DIV_HEIGHT: r_th    <= div_quo;
                    default: ;
                endcase
            end
            if (i_cmd.proc) begin
                if (row_end) begin
                    // a kept column implies a kept row, so the column restarts here
                    r_src_col <= '0;
                    r_err_col <= '0;
                    if (row_hit) begin
                        r_dst_row <= r_dst_row + DW'(1);
                        r_dst_col <= '0;
                    end
                    r_err_row <= r_err_row - {1'b0, r_th}
                               + (row_hit ? {1'b0, r_frame_h} : EW'(0));
                    r_src_row <= frame_end ? '0 : r_src_row + DW'(1);
                end else begin
                    r_src_col <= r_src_col + DW'(1);
                    if (col_hit) begin
                        r_dst_col <= r_dst_col + DW'(1);
                    end
                    if (row_hit) begin
                        r_err_col <= r_err_col - {1'b0, r_tw}
                                   + (col_hit ? {1'b0, r_frame_w} : EW'(0));
                    end
                end
            end
        end
    end

    // palette: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr && wr_in_range) begin
            r_pal[i_in_data.color_index[PAL_AW-1:0]] <=
                {i_in_data.entry_red, i_in_data.entry_green, i_in_data.entry_blue};
        end
        if (i_cmd.proc && col_hit) begin
            r_rgb <= rd_in_range ? r_pal[proc_idx[PAL_AW-1:0]] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.proc && col_hit) begin
            r_out_col  <= r_dst_col[ppnd_pkg::OUT_W-1:0];
            r_out_row  <= r_dst_row[ppnd_pkg::OUT_W-1:0];
            r_out_last <= last_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.proc && col_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_data.out_col    = r_out_col;
    assign o_out_data.out_row    = r_out_row;
    assign o_out_data.red        = r_rgb[3*ppnd_pkg::COLOR_W-1:2*ppnd_pkg::COLOR_W];
    assign o_out_data.green      = r_rgb[2*ppnd_pkg::COLOR_W-1:ppnd_pkg::COLOR_W];
    assign o_out_data.blue       = r_rgb[ppnd_pkg::COLOR_W-1:0];
    assign o_out_data.last_pixel = r_out_last;

    assign o_stat.at_start = (r_src_col == '0) && (r_src_row == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.div_done = div_done;

`ifndef ASSERT_OFF
    a_hit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.proc && col_hit) |=> r_out_valid)
        else $error("kept pixel did not reach the output register");

    a_dst_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dst_row <= r_th) && (r_dst_col <= r_tw))
        else $error("thumbnail position ran past the thumbnail size");
`endif

endmodule

`default_nettype wire

FILE: hdl/ppnd_ctrl.sv
// controller: request acceptance and frame-start division sequence
// depends on ppnd_pkg for the state, command and status types
`default_nettype none

module ppnd_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_func,
    input  wire ppnd_pkg::t_ctrl_stat i_stat,
    output logic                      o_in_ready,
    output ppnd_pkg::t_ctrl_cmd       o_cmd
);

    ppnd_pkg::t_state r_state;
    ppnd_pkg::t_state n_state;

    logic accept;
    logic is_pixel;

    assign is_pixel = (i_in_func == ppnd_pkg::FUNC_PIXEL);
    assign accept   = (r_state == ppnd_pkg::S_RUN) && i_in_valid && i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppnd_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppnd_pkg::S_RUN: begin
                if (accept && is_pixel && i_stat.at_start) n_state = ppnd_pkg::S_SC_LOAD;
            end
            ppnd_pkg::S_SC_LOAD: n_state = ppnd_pkg::S_SC_RUN;
            ppnd_pkg::S_SC_RUN: begin
                if (i_stat.div_done) n_state = ppnd_pkg::S_W_LOAD;
            end
            ppnd_pkg::S_W_LOAD: n_state = ppnd_pkg::S_W_RUN;
            ppnd_pkg::S_W_RUN: begin
                if (i_stat.div_done) n_state = ppnd_pkg::S_H_LOAD;
            end
            ppnd_pkg::S_H_LOAD: n_state = ppnd_pkg::S_H_RUN;
            ppnd_pkg::S_H_RUN: begin
                if (i_stat.div_done) n_state = ppnd_pkg::S_FIRST;
            end
            ppnd_pkg::S_FIRST: begin
                if (i_stat.out_free) n_state = ppnd_pkg::S_RUN;
            end
            default: n_state = ppnd_pkg::S_RUN;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.pal_wr     = 1'b0;
        o_cmd.proc       = 1'b0;
        o_cmd.use_held   = 1'b0;
        o_cmd.frame_init = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.div_sel    = ppnd_pkg::DIV_SCALE;
        unique case (r_state)
            ppnd_pkg::S_RUN: begin
                o_in_ready    = i_stat.out_free;
                o_cmd.capture = accept;
                o_cmd.pal_wr  = accept && !is_pixel;
                o_cmd.proc    = accept && is_pixel && !i_stat.at_start;
            end
            ppnd_pkg::S_SC_LOAD: begin
                o_cmd.frame_init = 1'b1;
                o_cmd.div_start  = 1'b1;
                o_cmd.div_sel    = ppnd_pkg::DIV_SCALE;
            end
            ppnd_pkg::S_SC_RUN: o_cmd.div_sel = ppnd_pkg::DIV_SCALE;
            ppnd_pkg::S_W_LOAD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = ppnd_pkg::DIV_WIDTH;
            end
            ppnd_pkg::S_W_RUN: o_cmd.div_sel = ppnd_pkg::DIV_WIDTH;
            ppnd_pkg::S_H_LOAD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = ppnd_pkg::DIV_HEIGHT;
            end
            ppnd_pkg::S_H_RUN: o_cmd.div_sel = ppnd_pkg::DIV_HEIGHT;
            ppnd_pkg::S_FIRST: begin
                o_cmd.proc     = i_stat.out_free;
                o_cmd.use_held = 1'b1;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_frame_start_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppnd_pkg::S_SC_LOAD) |-> ($past(r_state) == ppnd_pkg::S_RUN))
        else $error("frame start entered outside normal running");

    a_proc_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.proc |-> i_stat.out_free)
        else $error("pixel processed while output register is full");
`endif

endmodule

`default_nettype wire

FILE: hdl/palette_pixel_nearest_downscaler.sv
// top level of the palette thumbnail downscaler
// depends on ppnd_pkg, ppnd_ctrl, ppnd_dp (which holds ppnd_div)
`default_nettype none

// usage
// - configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 source width, 1 source height, 2 target size); write only while idle
// - input channel: valid/ready requests; func 0 writes a palette entry,
//   func 1 delivers the next source pixel in row-major order
// - output channel: valid/ready requests, one per kept pixel, with its
//   thumbnail column/row, palette colour and a flag on the frame's final pixel
// - throughput: one request per cycle while the output is not stalled, set
//   by the single output register and the registered palette read
// - a kept pixel other than a frame's first shows the cycle after acceptance
// - the first pixel of each frame runs the shared serial divider three times
//   (scale, thumbnail width, thumbnail height), one quotient bit a cycle, so
//   that pixel's result comes after the three divisions and no request is
//   taken meanwhile
// - column and row selection steps by adding and subtracting error terms per
//   source pixel and row, so no division happens per pixel
// - reset (synchronous, active low) restores the configuration registers to 1,
//   clears the scan position and empties the output; palette contents are kept
// - a stalled receiver holds the result in the output register; no request of
//   any kind is taken until that result is accepted
module palette_pixel_nearest_downscaler #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ppnd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ppnd_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ppnd_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ppnd_pkg::t_out_item                 o_out_data
);

    ppnd_pkg::t_ctrl_cmd  cmd;
    ppnd_pkg::t_ctrl_stat stat;

    // sequencing of requests and frame-start divisions
    ppnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_data.func),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // palette, scan counters and output register
    ppnd_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// self-checking testbench for palette_pixel_nearest_downscaler
// needs ppnd_pkg and the block's rtl; a cycle-free tracker predicts every kept pixel

module tb;

    localparam int DRAIN_CYCLES  = 64;    // first pixel of a frame runs three serial divisions
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
    localparam int RAND_ITEMS    = 1550;
    localparam int PAL_WRITE_PCT = 12;

    // predicts the thumbnail pixels from palette writes, registers and the pixel stream
    class thumbnail_tracker;
        logic [ppnd_pkg::RGB_W-1:0] palette_rgb [256];
        int unsigned      reg_w, reg_h, reg_t;
        int unsigned      src_col, src_row, dst_col, dst_row;
        int unsigned      want_col, want_row;
        int unsigned      thumb_w, thumb_h, frame_w, frame_h;
        ppnd_pkg::t_out_item pixels_due [$];
        int unsigned      mismatch_cnt;

        function new();
            reg_w = 1;
            reg_h = 1;
            reg_t = 1;
            src_col = 0;
            src_row = 0;
            dst_col = 0;
            dst_row = 0;
            want_col = 0;
            want_row = 0;
            thumb_w = 0;
            thumb_h = 0;
            frame_w = 0;
            frame_h = 0;
            mismatch_cnt = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v == 0) begin
                return 1;
            end
            return (v > 32'(ppnd_pkg::MAX_DIM)) ? 32'(ppnd_pkg::MAX_DIM) : v;
        endfunction

        function void write_reg(logic [ppnd_pkg::CFG_IDX_W-1:0] idx,
                                logic [ppnd_pkg::DIM_W-1:0] v);
            case (idx)
                ppnd_pkg::CFG_SRC_WIDTH: begin
                    reg_w = 32'(v);
                end
                ppnd_pkg::CFG_SRC_HEIGHT: begin
                    reg_h = 32'(v);
                end
                ppnd_pkg::CFG_TARGET_SIZE: begin
                    reg_t = 32'(v);
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(reg_w) * clamp_dim(reg_h);
        endfunction

        // source pixels still owed to the frame in progress
        function int unsigned pixels_to_frame_end();
            if (src_col == 0 && src_row == 0) begin
                return 0;
            end
            return frame_w * frame_h - (src_row * frame_w + src_col);
        endfunction

        function int unsigned pending();
            return pixels_due.size();
        endfunction

        function void note_request(ppnd_pkg::t_in_item req);
            int unsigned scale;
            bit          row_hit;
            ppnd_pkg::t_out_item res;
            logic [ppnd_pkg::RGB_W-1:0] rgb;
            if (req.func == ppnd_pkg::FUNC_PAL_WRITE) begin
                palette_rgb[req.color_index] = {req.entry_red, req.entry_green, req.entry_blue};
                return;
            end
            // registers are sampled only on the first pixel of a frame
            if (src_col == 0 && src_row == 0) begin
                frame_w = clamp_dim(reg_w);
                frame_h = clamp_dim(reg_h);
                scale   = (frame_w > clamp_dim(reg_t)) ? frame_w / clamp_dim(reg_t) : 1;
                thumb_w = frame_w / scale;
                thumb_h = frame_h / scale;
                dst_col = 0;
                dst_row = 0;
                want_col = 0;
                want_row = 0;
            end
            row_hit = (thumb_h != 0) && (dst_row < thumb_h) && (src_row == want_row);
            if (row_hit && dst_col < thumb_w && src_col == want_col) begin
                rgb = palette_rgb[req.color_index];
                res.out_col    = ppnd_pkg::OUT_W'(dst_col);
                res.out_row    = ppnd_pkg::OUT_W'(dst_row);
                res.red        = rgb[23:16];
                res.green      = rgb[15:8];
                res.blue       = rgb[7:0];
                res.last_pixel = (dst_row + 1 == thumb_h) && (dst_col + 1 == thumb_w);
                pixels_due.push_back(res);
                dst_col++;
                if (dst_col < thumb_w) begin
                    want_col = (dst_col * frame_w) / thumb_w;
                end
            end
            src_col++;
            if (src_col >= frame_w) begin
                src_col = 0;
                if (row_hit) begin
                    dst_row++;
                    dst_col = 0;
                    want_col = 0;
                    if (dst_row < thumb_h) begin
                        want_row = (dst_row * frame_h) / thumb_h;
                    end
                end
                src_row++;
                if (src_row >= frame_h) begin
                    src_row = 0;
                end
            end
        endfunction

        function string show(ppnd_pkg::t_out_item p);
            return $sformatf("col %0d row %0d rgb %02h%02h%02h last %0b",
                             p.out_col, p.out_row, p.red, p.green, p.blue, p.last_pixel);
        endfunction

        function void check_pixel(ppnd_pkg::t_out_item got);
            ppnd_pkg::t_out_item want;
            if (pixels_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%0t: unexpected pixel, got %s", $time, show(got));
                end
                return;
            end
            want = pixels_due.pop_front();
            if (got.out_col !== want.out_col || got.out_row !== want.out_row ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.last_pixel !== want.last_pixel) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%0t: pixel mismatch, expected %s, got %s",
                             $time, show(want), show(got));
                end
            end
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [ppnd_pkg::CFG_IDX_W-1:0] i_cfg_index = ppnd_pkg::CFG_SRC_WIDTH;
    logic [ppnd_pkg::DIM_W-1:0]     i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    ppnd_pkg::t_in_item             i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    ppnd_pkg::t_out_item            o_out_data;

    thumbnail_tracker sb = new();

    int unsigned in_idle_pct  = 33;
    int unsigned out_idle_pct = 68;
    int unsigned items_sent   = 0;
    int unsigned stall_cycles = 0;
    logic [ppnd_pkg::IDX_W-1:0] written_idx [$];  // palette entries safe to read
    bit                         is_written  [256];

    palette_pixel_nearest_downscaler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // receiver: random back-pressure, changed only on the falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pixel(o_out_data);
        end
    end

    // watchdog on cycles without any handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one request: optional idle gap, then valid held until the handshake
    task automatic send_request(input ppnd_pkg::t_in_item req);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_request(req);
        items_sent++;
    endtask

    task automatic send_palette_write(input logic [ppnd_pkg::IDX_W-1:0] idx,
                                      input logic [ppnd_pkg::RGB_W-1:0] rgb);
        ppnd_pkg::t_in_item req;
        req.func        = ppnd_pkg::FUNC_PAL_WRITE;
        req.color_index = idx;
        req.entry_red   = rgb[23:16];
        req.entry_green = rgb[15:8];
        req.entry_blue  = rgb[7:0];
        if (!is_written[idx]) begin
            is_written[idx] = 1'b1;
            written_idx.push_back(idx);
        end
        send_request(req);
    endtask

    task automatic send_pixel(input logic [ppnd_pkg::IDX_W-1:0] idx);
        ppnd_pkg::t_in_item req;
        req.func        = ppnd_pkg::FUNC_PIXEL;
        req.color_index = idx;
        // colour fields are don't-care on a pixel, keep them moving anyway
        req.entry_red   = ppnd_pkg::COLOR_W'($urandom_range(255));
        req.entry_green = ppnd_pkg::COLOR_W'($urandom_range(255));
        req.entry_blue  = ppnd_pkg::COLOR_W'($urandom_range(255));
        send_request(req);
    endtask

    // pixels from written entries only, with palette updates mixed in
    task automatic send_pixels(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(99) < PAL_WRITE_PCT) begin
                send_palette_write(ppnd_pkg::IDX_W'($urandom_range(255)),
                                   ppnd_pkg::RGB_W'($urandom));
            end
            send_pixel(written_idx[$urandom_range(written_idx.size() - 1)]);
        end
    endtask

    // drop valid, let all results arrive, then cover a possible busy first pixel
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ppnd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppnd_pkg::DIM_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_regs(input logic [ppnd_pkg::DIM_W-1:0] w,
                              input logic [ppnd_pkg::DIM_W-1:0] h,
                              input logic [ppnd_pkg::DIM_W-1:0] t);
        wait_idle();
        write_reg(ppnd_pkg::CFG_SRC_WIDTH, w);
        write_reg(ppnd_pkg::CFG_SRC_HEIGHT, h);
        write_reg(ppnd_pkg::CFG_TARGET_SIZE, t);
    endtask

    initial begin
        logic [ppnd_pkg::DIM_W-1:0] w, h, t;
        int unsigned                rand_base, n;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: palette extremes first so no pixel ever reads an unwritten entry
        send_palette_write(8'h00, 24'hffffff);
        send_palette_write(8'hff, 24'h000000);
        send_palette_write(8'ha5, 24'h5aa53c);
        send_palette_write(8'h5a, 24'ha55ac3);
        // 1x1 frame on reset register values
        send_pixel(8'hff);
        // zero width and zero target read as one, 1x2 thumbnail
        write_regs(13'd0, 13'd2, 13'd0);
        send_pixel(8'h5a);
        // height change in mid-frame only applies to the next frame
        wait_idle();
        write_reg(ppnd_pkg::CFG_SRC_HEIGHT, 13'd1);
        send_pixel(8'ha5);
        send_pixel(8'h00);
        // scale 3 gives a zero-row thumbnail: pixels consumed, nothing produced
        write_regs(13'd3, 13'd1, 13'd1);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'h5a);
        // scale 2 on a 4x2 source keeps columns 0 and 2 of row 0
        write_regs(13'd4, 13'd2, 13'd2);
        for (int k = 0; k < 8; k++) begin
            send_pixel((k % 2) ? 8'ha5 : 8'h5a);
        end

        // oversize target clamps to the limit, so the whole 6x2 source is kept
        write_regs(13'd6, 13'd2, 13'd8191);
        send_pixels(sb.frame_pixels());

        // random settings, mostly whole frames, some cut short in mid-frame
        rand_base = items_sent;
        while (items_sent - rand_base < RAND_ITEMS) begin
            if (items_sent - rand_base < RAND_ITEMS / 3) begin
                in_idle_pct  = 33;
                out_idle_pct = 68;
            end else if (items_sent - rand_base < 2 * RAND_ITEMS / 3) begin
                in_idle_pct  = 68;
                out_idle_pct = 33;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            case ($urandom_range(9))
                0: w = 13'd0;
                1: w = ppnd_pkg::DIM_W'($urandom_range(13, 64));
                default: w = ppnd_pkg::DIM_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(9))
                0: h = 13'd0;
                1: h = ppnd_pkg::DIM_W'($urandom_range(9, 16));
                default: h = ppnd_pkg::DIM_W'($urandom_range(1, 8));
            endcase
            if (w > 12) begin
                h = ppnd_pkg::DIM_W'($urandom_range(0, 3));
            end
            case ($urandom_range(9))
                0: t = 13'd0;
                1: t = ppnd_pkg::DIM_W'($urandom_range(4097, 8191));
                2: t = ppnd_pkg::DIM_W'($urandom_range(13, 4096));
                default: t = ppnd_pkg::DIM_W'($urandom_range(1, 12));
            endcase
            write_regs(w, h, t);
            n = sb.pixels_to_frame_end() + $urandom_range(1, 3) * sb.frame_pixels();
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, n);
            end
            send_pixels(n);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
